### hdl/cmrl_pkg.sv
// Shared types and codes for the control message rate limiter.
// No dependencies; imported by every module of the block.
package cmrl_pkg;

  localparam int TIME_W = 32;
  localparam int WIN_W  = 16;

  // message kinds
  localparam logic [1:0] TYPE_REQUEST = 2'd0;
  localparam logic [1:0] TYPE_REPLY   = 2'd1;
  localparam logic [1:0] TYPE_ERROR   = 2'd2;
  localparam logic [1:0] TYPE_OTHER   = 2'd3;

  // drop reasons
  localparam logic [1:0] WHY_NONE = 2'd0;
  localparam logic [1:0] WHY_HELD = 2'd1;
  localparam logic [1:0] WHY_RATE = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_LIMITER_ENABLE = 2'd0;
  localparam logic [1:0] CFG_HOLD_REPLIES   = 2'd1;
  localparam logic [1:0] CFG_WINDOW_MS      = 2'd2;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

  // per-log control from the pipeline
  typedef struct packed {
    logic rd_en;   // new transaction accepted: fetch oldest entry
    logic upd_en;  // decision stage commits a message of this log
  } cmrl_log_ctl_t;

endpackage

### hdl/cmrl_log.sv
// One send-time log: ring memory with head pointer and fill count.
// Depends on cmrl_pkg.
module cmrl_log #(
  parameter int DEPTH = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmrl_pkg::cmrl_log_ctl_t     ctl,
  input  logic [cmrl_pkg::TIME_W-1:0] now,
  input  logic [cmrl_pkg::WIN_W-1:0]  window,
  output logic                        admit
);
  import cmrl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [TIME_W-1:0] mem [DEPTH];
  logic [TIME_W-1:0] stored_r;
  logic [TIME_W-1:0] fwd_data_r;
  logic              fwd_hit_r;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  logic              full;
  logic [TIME_W-1:0] oldest;
  logic [TIME_W-1:0] age;
  logic [AW:0]       slot_sum;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     head_inc;
  logic [AW-1:0]     wr_addr;
  logic              wr_en;

  assign full   = (count_r == CW'(DEPTH));
  assign oldest = fwd_hit_r ? fwd_data_r : stored_r;
  assign age    = now - oldest;
  assign admit  = !full || (age >= {{(TIME_W-WIN_W){1'b0}}, window});

  assign slot_sum = {1'b0, head_r} + (AW+1)'(count_r);
  assign slot     = (slot_sum >= (AW+1)'(DEPTH)) ? AW'(slot_sum - (AW+1)'(DEPTH))
                                                  : slot_sum[AW-1:0];
  assign head_inc = ((AW+1)'(head_r) + (AW+1)'(1) >= (AW+1)'(DEPTH)) ? '0
                                                                    : head_r + AW'(1);

  assign wr_en   = ctl.upd_en && admit;
  assign wr_addr = full ? head_r : slot;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (wr_en) begin
      if (full) begin
        head_nxt = head_inc;  // overwrite oldest, advance
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (ctl.rd_en) begin
        fwd_hit_r <= wr_en && (wr_addr == head_nxt);
      end
    end
  end

  // memory: read oldest entry at the head the next message will see
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= now;
    end
    if (ctl.rd_en) begin
      stored_r   <= mem[head_nxt];
      fwd_data_r <= now;
    end
  end

endmodule

### hdl/control_message_rate_limiter.sv
// Top level of the control message rate limiter.
// Depends on cmrl_pkg and cmrl_log.
//
// Usage: each input transaction carries one outgoing control message
// (in_tuser = message kind, in_tdata = current time in ms). Each produces
// exactly one result transaction (send_ok, drop_reason), in order.
// Configuration (limiter enable, reply hold, window length) is written
// through cfg_we/cfg_addr/cfg_wdata while no message is in flight.
// Path: an accepted input loads the decision stage together with the log
// memory read; the result then goes to the output register.
// Throughput: one message per cycle unless the receiver stalls. The
// decision for a message and the log write-back happen in the same
// cycle, and the next message's read address comes from the updated
// head pointer, with write forwarding when both touch the same log entry.
// Reset (rst_n low, synchronous) empties both logs, restores the
// register defaults and clears all valid flags; log contents are not
// cleared. When the receiver stalls, the result holds in the output
// register and the decision stage holds; in_tready drops only when both
// are occupied and out_tready is low.
module control_message_rate_limiter #(
  parameter int REQUEST_LIMIT = 10,
  parameter int ERROR_LIMIT   = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] now_ms
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] send_ok, [2:1] drop_reason, [7:3] zero
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import cmrl_pkg::*;

  // configuration registers
  logic             limiter_enable_r;
  logic             hold_replies_r;
  logic [WIN_W-1:0] window_ms_r;

  // decision stage
  logic              s1_valid_r;
  logic [1:0]        s1_type_r;
  logic [TIME_W-1:0] s1_now_r;

  // output register
  logic       out_valid_r;
  logic       out_send_ok_r;
  logic [1:0] out_reason_r;

  logic          in_fire, s1_adv, s1_fire;
  logic          req_admit, err_admit;
  logic [1:0]    why;
  cmrl_log_ctl_t req_ctl, err_ctl;

  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // reply hold wins, then the per-kind log when limiting is on
  always_comb begin
    why = WHY_NONE;
    if (hold_replies_r && (s1_type_r == TYPE_REPLY)) begin
      why = WHY_HELD;
    end else if (limiter_enable_r) begin
      if ((s1_type_r == TYPE_REQUEST) && !req_admit) begin
        why = WHY_RATE;
      end else if ((s1_type_r == TYPE_ERROR) && !err_admit) begin
        why = WHY_RATE;
      end
    end
  end

  // both logs fetch on every accepted message; only the matching one commits
  assign req_ctl.rd_en  = in_fire;
  assign req_ctl.upd_en = s1_fire && limiter_enable_r && (s1_type_r == TYPE_REQUEST);
  assign err_ctl.rd_en  = in_fire;
  assign err_ctl.upd_en = s1_fire && limiter_enable_r && (s1_type_r == TYPE_ERROR);

  cmrl_log #(.DEPTH(REQUEST_LIMIT - 1)) u_req_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (req_ctl),
    .now    (s1_now_r),
    .window (window_ms_r),
    .admit  (req_admit)
  );

  cmrl_log #(.DEPTH(ERROR_LIMIT - 1)) u_err_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (err_ctl),
    .now    (s1_now_r),
    .window (window_ms_r),
    .admit  (err_admit)
  );

  // configuration writes; unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limiter_enable_r <= 1'b1;
      hold_replies_r   <= 1'b0;
      window_ms_r      <= WINDOW_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LIMITER_ENABLE: limiter_enable_r <= cfg_wdata[0];
        CFG_HOLD_REPLIES:   hold_replies_r   <= cfg_wdata[0];
        CFG_WINDOW_MS:      window_ms_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control: advance stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_fire;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_type_r <= in_tuser;
      s1_now_r  <= in_tdata;
    end
    if (s1_fire) begin
      out_send_ok_r <= (why == WHY_NONE);
      out_reason_r  <= why;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_reason_r, out_send_ok_r};

endmodule

### hdl/cmrl_checker.sv
// Port-level checks for the control message rate limiter, bound to the top.
// Depends on cmrl_pkg and control_message_rate_limiter.
module cmrl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);
  import cmrl_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // send_ok set exactly when there is no drop reason
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] == (out_tdata[2:1] == WHY_NONE)))
    else $error("send_ok and drop_reason disagree");

  // only defined reasons, padding bits zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:3] == 5'd0) &&
                   ((out_tdata[2:1] == WHY_NONE) || (out_tdata[2:1] == WHY_HELD) ||
                    (out_tdata[2:1] == WHY_RATE)))
    else $error("bad result encoding");

  // with nothing waiting at the output the block takes input
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // reset clears the result channel
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind control_message_rate_limiter cmrl_checker u_cmrl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
